@@ hw/rtl/cosine_sine_taylor_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Cosine/sine unit assertion macros
// Concurrent checks clocked on clk, with and without the reset guard.
// ----------------------------------------------------------------------------
`ifndef COSINE_SINE_TAYLOR_UNIT_MACROS_SVH
`define COSINE_SINE_TAYLOR_UNIT_MACROS_SVH

// same-cycle implication, off while rst is high
`define CST_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cosine_sine_taylor_unit check failed");

// next-cycle implication, off while rst is high
`define CST_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cosine_sine_taylor_unit check failed");

// next-cycle implication, live through reset
`define CST_ASSERT_NEXT_ANY(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("cosine_sine_taylor_unit check failed");

`endif

@@ hw/rtl/cst_pkg.sv @@
// ----------------------------------------------------------------------------
// cst_pkg
// Shared constants, series divisor tables and pipeline word types.
// ----------------------------------------------------------------------------
package cst_pkg;

  localparam int MAX_TERMS_DEFAULT = 7;
  localparam int TERM_LIMIT        = 7;
  localparam logic [2:0] TERM_COUNT_RESET = 3'd6;

  // pi/2 and 1.0 in Q.30
  localparam logic [30:0] HALF_PI = 31'd1686629713;
  localparam logic [30:0] ONE     = 31'h4000_0000;

  localparam int QBITS    = 8;   // quarter-turn count bits
  localparam int MAG_W    = 38;  // |angle| in Q.30
  localparam int SUM_W    = 34;
  localparam int SCALED_W = 33;  // scaled product fed to the divider

  // (2k-1)(2k) and floor(2^33 / that); entry 0 unused
  localparam logic [7:0] PAIR_DIV [TERM_LIMIT] =
    '{8'd1, 8'd2, 8'd12, 8'd30, 8'd56, 8'd90, 8'd132};
  localparam logic [SCALED_W-1:0] PAIR_RECIP [TERM_LIMIT] =
    '{33'd0, 33'd4294967296, 33'd715827882, 33'd286331153,
      33'd153391689, 33'd95443717, 33'd65075262};

  typedef struct packed {
    logic [1:0] quad;
    logic [2:0] lim;
  } cst_side_t;

  typedef struct packed {
    cst_side_t                 side;
    logic [31:0]               x2;
    logic [30:0]               term;
    logic signed [SUM_W-1:0]   sum;
  } cst_acc_t;

endpackage

@@ hw/rtl/cst_reduce.sv @@
// ----------------------------------------------------------------------------
// cst_reduce
// Absolute angle, quarter-turn reduction by restoring division (two
// quotient bits a stage) and fold of odd quarters.
// ----------------------------------------------------------------------------
module cst_reduce #(
  parameter int MAX_TERMS = cst_pkg::MAX_TERMS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                cmd,
  input  logic signed [31:0]  angle,
  input  logic [2:0]          term_count,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [30:0]         xmag,
  output cst_pkg::cst_side_t  side
);

  localparam int MW     = cst_pkg::MAG_W;
  localparam int DIVS   = cst_pkg::QBITS / 2;
  localparam int STAGES = DIVS + 2;

  logic [STAGES-1:0] vld;
  logic [STAGES:0]   rdy;
  logic [STAGES-1:0] vld_src;

  logic [MW-1:0] rem      [DIVS+1];
  logic [MW-1:0] rem_next [DIVS+1];
  logic [2:0]    lim_p    [DIVS+1];
  logic [1:0]    quad;
  logic [1:0]    quad_next;
  logic [2:0]    lim_in;
  logic [30:0]   xmag_r;
  cst_pkg::cst_side_t side_r;

  logic signed [38:0] wide;
  logic signed [38:0] shifted;
  logic signed [38:0] absval;

  assign rdy[STAGES] = out_ready;
  for (genvar s = 0; s < STAGES; s++) begin : g_rdy
    assign rdy[s] = !vld[s] || rdy[s+1];
  end
  assign in_ready = rdy[0];
  assign vld_src  = {vld[STAGES-2:0], in_valid};

  assign lim_in = (term_count < 3'(MAX_TERMS)) ? term_count : 3'(MAX_TERMS);

  always_comb begin
    wide    = {angle[31], angle, 6'b0};
    shifted = cmd ? wide - 39'(cst_pkg::HALF_PI) : wide;
    absval  = shifted[38] ? -shifted : shifted;
  end

  always_comb begin
    logic [MW-1:0] t;
    logic [MW-1:0] dv;
    logic [1:0]    qp;
    rem_next[0] = MW'(absval);
    qp = 2'b00;
    for (int d = 1; d <= DIVS; d++) begin
      t = rem[d-1];
      for (int j = 0; j < 2; j++) begin
        dv = MW'(cst_pkg::HALF_PI) << (cst_pkg::QBITS - 1 - 2 * (d - 1) - j);
        qp[1-j] = (t >= dv);
        if (qp[1-j]) begin
          t = t - dv;
        end
      end
      rem_next[d] = t;
    end
    quad_next = qp;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int s = 0; s < STAGES; s++) begin
        if (rdy[s]) begin
          vld[s] <= vld_src[s];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      lim_p[0] <= lim_in;
    end
    for (int d = 0; d <= DIVS; d++) begin
      if (rdy[d]) begin
        rem[d] <= rem_next[d];
      end
    end
    for (int d = 1; d <= DIVS; d++) begin
      if (rdy[d]) begin
        lim_p[d] <= lim_p[d-1];
      end
    end
    if (rdy[DIVS]) begin
      quad <= quad_next;
    end
    if (rdy[DIVS+1]) begin
      xmag_r      <= quad[0] ? cst_pkg::HALF_PI - rem[DIVS][30:0] : rem[DIVS][30:0];
      side_r.quad <= quad;
      side_r.lim  <= lim_p[DIVS];
    end
  end

  assign out_valid = vld[STAGES-1];
  assign xmag      = xmag_r;
  assign side      = side_r;

endmodule

@@ hw/rtl/cst_square.sv @@
// ----------------------------------------------------------------------------
// cst_square
// Squares the folded residue, rounds to Q2.30 and seeds the series word.
// ----------------------------------------------------------------------------
module cst_square (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [30:0]         xmag,
  input  cst_pkg::cst_side_t  side,
  output logic                out_valid,
  input  logic                out_ready,
  output cst_pkg::cst_acc_t   acc
);

  localparam int SW = cst_pkg::SUM_W;
  localparam logic signed [SW-1:0] ONE_SUM = SW'(cst_pkg::ONE);

  logic [1:0] vld;
  logic [2:0] rdy;

  logic [61:0]        prod;
  cst_pkg::cst_side_t side0;
  cst_pkg::cst_acc_t  acc_r;

  assign rdy[2]   = out_ready;
  assign rdy[1]   = !vld[1] || rdy[2];
  assign rdy[0]   = !vld[0] || rdy[1];
  assign in_ready = rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= in_valid;
      end
      if (rdy[1]) begin
        vld[1] <= vld[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      prod  <= xmag * xmag;
      side0 <= side;
    end
    if (rdy[1]) begin
      acc_r.side <= side0;
      acc_r.x2   <= 32'((prod + (62'd1 << 29)) >> 30);
      acc_r.term <= cst_pkg::ONE;
      acc_r.sum  <= (side0.lim != 3'd0) ? ONE_SUM : '0;
    end
  end

  assign out_valid = vld[1];
  assign acc       = acc_r;

endmodule

@@ hw/rtl/cst_term.sv @@
// ----------------------------------------------------------------------------
// cst_term
// One series term: product with x^2, rounded divide by (2k-1)(2k) through a
// reciprocal with one correction, signed add into the running sum (IDX < lim).
// ----------------------------------------------------------------------------
module cst_term #(
  parameter int IDX = 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  cst_pkg::cst_acc_t  in_acc,
  output logic               out_valid,
  input  logic               out_ready,
  output cst_pkg::cst_acc_t  out_acc
);

  localparam int QW = cst_pkg::SCALED_W;
  localparam int SW = cst_pkg::SUM_W;
  localparam logic [7:0]    P   = cst_pkg::PAIR_DIV[IDX];
  localparam logic [QW-1:0] REC = cst_pkg::PAIR_RECIP[IDX];
  localparam bit ODD = (IDX % 2) == 1;

  logic [2:0] vld;
  logic [3:0] rdy;

  logic [62:0]         prod;
  logic [QW-1:0]       s_next;
  logic [QW-1:0]       s1;
  logic [2*QW-1:0]     m;
  logic [QW-1:0]       q0;
  logic [QW-1:0]       rmd;
  logic [QW-1:0]       tk;
  logic signed [SW-1:0] delta;
  logic signed [SW-1:0] sum_next;
  cst_pkg::cst_acc_t   acc0;
  cst_pkg::cst_acc_t   acc1;
  cst_pkg::cst_acc_t   acc2;

  assign rdy[3]   = out_ready;
  for (genvar s = 0; s < 3; s++) begin : g_rdy
    assign rdy[s] = !vld[s] || rdy[s+1];
  end
  assign in_ready = rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= in_valid;
      end
      if (rdy[1]) begin
        vld[1] <= vld[0];
      end
      if (rdy[2]) begin
        vld[2] <= vld[1];
      end
    end
  end

  always_comb begin
    s_next = QW'((prod + (63'(P) << 29)) >> 30);
    q0     = m[2*QW-1:QW];
    rmd    = s1 - q0 * QW'(P);
    tk     = (rmd >= QW'(P)) ? q0 + QW'(1) : q0;
    delta  = SW'(tk[30:0]);
    if (3'(IDX) < acc1.side.lim) begin
      sum_next = ODD ? acc1.sum - delta : acc1.sum + delta;
    end else begin
      sum_next = acc1.sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      prod <= in_acc.term * in_acc.x2;
      acc0 <= in_acc;
    end
    if (rdy[1]) begin
      m    <= s_next * REC;
      s1   <= s_next;
      acc1 <= acc0;
    end
    if (rdy[2]) begin
      acc2.side <= acc1.side;
      acc2.x2   <= acc1.x2;
      acc2.term <= tk[30:0];
      acc2.sum  <= sum_next;
    end
  end

  assign out_valid = vld[2];
  assign out_acc   = acc2;

endmodule

@@ hw/rtl/cst_out.sv @@
// ----------------------------------------------------------------------------
// cst_out
// Quadrant sign, clamp to plus or minus one, and the output register.
// ----------------------------------------------------------------------------
module cst_out (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  cst_pkg::cst_acc_t  in_acc,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] value
);

  localparam int SW = cst_pkg::SUM_W;
  localparam logic signed [SW-1:0] ONE_SUM = SW'(cst_pkg::ONE);

  logic                 vld;
  logic                 rdy;
  logic                 neg;
  logic signed [SW-1:0] signed_sum;
  logic signed [SW-1:0] clamped;
  logic signed [31:0]   value_r;

  assign rdy      = !vld || out_ready;
  assign in_ready = rdy;

  always_comb begin
    neg        = (in_acc.side.quad == 2'd1) || (in_acc.side.quad == 2'd2);
    signed_sum = neg ? -in_acc.sum : in_acc.sum;
    if (signed_sum > ONE_SUM) begin
      clamped = ONE_SUM;
    end else if (signed_sum < -ONE_SUM) begin
      clamped = -ONE_SUM;
    end else begin
      clamped = signed_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (rdy) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy) begin
      value_r <= 32'(clamped);
    end
  end

  assign out_valid = vld;
  assign value     = value_r;

endmodule

@@ hw/rtl/cosine_sine_taylor_unit.sv @@
// ----------------------------------------------------------------------------
// cosine_sine_taylor_unit
// Cosine or sine of a Q8.24 angle by quarter-turn reduction and a truncated
// even Taylor series, result in Q2.30 clamped to plus or minus one.
//
//   port group   dir   handshake             word
//   in           in    in_valid / in_stall   cmd, angle
//   out          out   out_valid / out_stall value
//   cfg          in    cfg_we                cfg_wdata (term_count)
//
// One word a cycle in and out while out_stall is low. Each term stage has
// three registers (multiply, reciprocal multiply, correct and add).
// Reset clears every valid bit and loads term_count with 6.
// An output stall holds the output register; bubbles close up behind it and
// in_stall rises only once every stage holds a word.
// ----------------------------------------------------------------------------
module cosine_sine_taylor_unit #(
  parameter int MAX_TERMS = cst_pkg::MAX_TERMS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               cmd,
  input  logic signed [31:0] angle,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] value,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_wdata
);

  logic [2:0] term_count;

  logic               red_ready;
  logic               red_valid;
  logic               sq_ready;
  logic [30:0]        xmag;
  cst_pkg::cst_side_t side;

  logic [MAX_TERMS-1:0] vld_c;
  logic [MAX_TERMS-1:0] rdy_c;
  cst_pkg::cst_acc_t    acc_c [MAX_TERMS];

  always_ff @(posedge clk) begin
    if (rst) begin
      term_count <= cst_pkg::TERM_COUNT_RESET;
    end else if (cfg_we) begin
      term_count <= cfg_wdata;
    end
  end

  assign in_stall = !red_ready;

  cst_reduce #(.MAX_TERMS(MAX_TERMS)) u_reduce (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (red_ready),
    .cmd        (cmd),
    .angle      (angle),
    .term_count (term_count),
    .out_valid  (red_valid),
    .out_ready  (sq_ready),
    .xmag       (xmag),
    .side       (side)
  );

  cst_square u_square (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (red_valid),
    .in_ready  (sq_ready),
    .xmag      (xmag),
    .side      (side),
    .out_valid (vld_c[0]),
    .out_ready (rdy_c[0]),
    .acc       (acc_c[0])
  );

  for (genvar k = 1; k < MAX_TERMS; k++) begin : g_term
    cst_term #(.IDX(k)) u_term (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (vld_c[k-1]),
      .in_ready  (rdy_c[k-1]),
      .in_acc    (acc_c[k-1]),
      .out_valid (vld_c[k]),
      .out_ready (rdy_c[k]),
      .out_acc   (acc_c[k])
    );
  end

  cst_out u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vld_c[MAX_TERMS-1]),
    .in_ready  (rdy_c[MAX_TERMS-1]),
    .in_acc    (acc_c[MAX_TERMS-1]),
    .out_valid (out_valid),
    .out_ready (!out_stall),
    .value     (value)
  );

endmodule

@@ hw/rtl/cst_checker.sv @@
// ----------------------------------------------------------------------------
// cst_checker
// Port-level checks on the cosine/sine unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "cosine_sine_taylor_unit_macros.svh"

module cst_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] value
);

  // a word out is always within plus or minus one
  `CST_ASSERT_NOW(a_value_range, out_valid, (value <= 32'sh4000_0000) && (value >= -32'sh4000_0000))

  // input only backs up when the output is full and stalled
  `CST_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall)

  // a stalled word stays put
  `CST_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(value))

  // nothing leaves straight after reset
  `CST_ASSERT_NEXT_ANY(a_reset_empty, rst, !out_valid)

endmodule

bind cosine_sine_taylor_unit cst_checker u_cst_checker (.*);
